[hw/rtl/motor_response_frame_checker_defines.svh]
// Assertion macros used by the frame checker's assertion module.
`ifndef MOTOR_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define MOTOR_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MRFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MRFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define MRFC_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mrfc_pkg.sv]
// Types, constants and the CRC step function of the response frame checker.
package mrfc_pkg;

  localparam int FRAME_LENGTH = 38;
  localparam int IDX_W        = 6;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR = 2'd1;
  localparam logic [1:0] ST_BAD_FUNC = 2'd2;
  localparam logic [1:0] ST_BAD_CRC  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION_CODE = 1'b1;

  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
  localparam logic [7:0] FUNCTION_CODE_RESET = 8'd0;

  // Byte positions inside the frame.
  localparam logic [IDX_W-1:0] IDX_ADDR         = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_FUNC         = IDX_W'(1);
  localparam int               WIDE_FIRST       = 2;
  localparam int               NARROW_FIRST     = 18;
  localparam int               NUM_WIDE         = 4;
  localparam int               NUM_NARROW       = 6;
  localparam logic [IDX_W-1:0] IDX_ERR_HI       = IDX_W'(32);
  localparam logic [IDX_W-1:0] IDX_ERR_LO       = IDX_W'(33);
  localparam logic [IDX_W-1:0] IDX_CRC_LO       = IDX_W'(FRAME_LENGTH - 2);
  localparam logic [IDX_W-1:0] IDX_CRC_HI       = IDX_W'(FRAME_LENGTH - 1);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] shaft_force;
    logic signed [31:0] shaft_position;
    logic signed [31:0] speed;
    logic signed [31:0] acceleration;
    logic signed [15:0] board_temp;
    logic signed [15:0] coil_temp;
    logic signed [15:0] voltage;
    logic signed [15:0] power;
    logic signed [15:0] op_mode;
    logic signed [15:0] error_bits;
  } result_t;

  // One byte of reflected CRC-16, bit by bit.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/mrfc_ifs.sv]
// Valid/ready channel interfaces for input bytes, results and configuration.
interface mrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, rx_byte, restart, input ready);
  modport sink   (input valid, rx_byte, restart, output ready);
  modport mon    (input valid, ready, rx_byte, restart);
endinterface

interface mrfc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] shaft_force;
  logic signed [31:0] shaft_position;
  logic signed [31:0] speed;
  logic signed [31:0] acceleration;
  logic signed [15:0] board_temp;
  logic signed [15:0] coil_temp;
  logic signed [15:0] voltage;
  logic signed [15:0] power;
  logic signed [15:0] op_mode;
  logic signed [15:0] error_bits;

  modport source (output valid, status, shaft_force, shaft_position, speed, acceleration,
                  board_temp, coil_temp, voltage, power, op_mode, error_bits,
                  input ready);
  modport sink   (input valid, status, shaft_force, shaft_position, speed, acceleration,
                  board_temp, coil_temp, voltage, power, op_mode, error_bits,
                  output ready);
  modport mon    (input valid, ready, status, shaft_force, shaft_position, speed,
                  acceleration, board_temp, coil_temp, voltage, power, op_mode, error_bits);
endinterface

interface mrfc_cfg_if;
  import mrfc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

[hw/rtl/mrfc_in_stage.sv]
// Input register that holds one received word until the frame logic takes it.
module mrfc_in_stage (
  input  logic              clk,
  input  logic              rst,
  mrfc_in_if.sink           in_ch,
  input  logic              take,
  output mrfc_pkg::in_word_t word,
  output logic              word_valid
);
  import mrfc_pkg::*;

  assign in_ch.ready = !word_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ch.ready) begin
      word_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word <= '{rx_byte: in_ch.rx_byte, restart: in_ch.restart};
    end
  end

endmodule

[hw/rtl/mrfc_frame_proc.sv]
// Frame position, header check, field gathering and running CRC per byte.
module mrfc_frame_proc (
  input  logic               clk,
  input  logic               rst,
  mrfc_cfg_if.sink           cfg_ch,
  input  mrfc_pkg::in_word_t word,
  input  logic               word_valid,
  input  logic               out_free,
  output logic               take,
  output logic               res_load,
  output mrfc_pkg::result_t  res
);
  import mrfc_pkg::*;

  logic [7:0]       slave_address;
  logic [7:0]       function_code;
  logic [IDX_W-1:0] byte_index;
  logic [15:0]      crc_acc;
  logic [1:0]       header_status;
  logic [31:0]      wide_fields [NUM_WIDE];
  logic [15:0]      narrow_fields [NUM_NARROW];
  logic [7:0]       crc_low_byte;

  logic [IDX_W-1:0] idx;
  logic             last;
  logic [7:0]       b;
  logic [15:0]      crc_next;
  logic [1:0]       status_final;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RESET;
      function_code <= FUNCTION_CODE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SLAVE_ADDRESS: slave_address <= cfg_ch.data;
        CFG_FUNCTION_CODE: function_code <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign b        = word.rx_byte;
  assign idx      = word.restart ? IDX_ADDR : byte_index;
  assign last     = (idx >= IDX_CRC_HI);
  assign take     = word_valid && (!last || out_free);
  assign res_load = take && last;
  assign crc_next = crc16_byte((idx == IDX_ADDR) ? CRC_INIT : crc_acc, b);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      crc_acc       <= CRC_INIT;
      header_status <= ST_OK;
      crc_low_byte  <= '0;
      for (int w = 0; w < NUM_WIDE; w++) begin
        wide_fields[w] <= '0;
      end
      for (int n = 0; n < NUM_NARROW; n++) begin
        narrow_fields[n] <= '0;
      end
    end else if (take) begin
      byte_index <= last ? '0 : idx + IDX_W'(1);

      if (idx < IDX_CRC_LO) begin
        crc_acc <= crc_next;
      end
      if (idx == IDX_CRC_LO) begin
        crc_low_byte <= b;
      end

      if (idx == IDX_ADDR) begin
        header_status <= (b != slave_address) ? ST_BAD_ADDR : ST_OK;
      end else if (idx == IDX_FUNC && header_status == ST_OK && b != function_code) begin
        header_status <= ST_BAD_FUNC;
      end

      // Big-endian words shift in one byte at a time.
      for (int w = 0; w < NUM_WIDE; w++) begin
        if (idx >= IDX_W'(WIDE_FIRST + 4 * w) && idx <= IDX_W'(WIDE_FIRST + 4 * w + 3)) begin
          wide_fields[w] <= {wide_fields[w][23:0], b};
        end
      end
      for (int n = 0; n < NUM_NARROW - 1; n++) begin
        if (idx >= IDX_W'(NARROW_FIRST + 2 * n) && idx <= IDX_W'(NARROW_FIRST + 2 * n + 1)) begin
          narrow_fields[n] <= {narrow_fields[n][7:0], b};
        end
      end
      if (idx == IDX_ERR_HI || idx == IDX_ERR_LO) begin
        narrow_fields[NUM_NARROW-1] <= {narrow_fields[NUM_NARROW-1][7:0], b};
      end
    end
  end

  // Header errors take precedence over a CRC mismatch.
  always_comb begin
    status_final = header_status;
    if (header_status == ST_OK && (crc_low_byte != crc_acc[7:0] || b != crc_acc[15:8])) begin
      status_final = ST_BAD_CRC;
    end
  end

  assign res = '{
    status:         status_final,
    shaft_force:    wide_fields[0],
    shaft_position: wide_fields[1],
    speed:          wide_fields[2],
    acceleration:   wide_fields[3],
    board_temp:     narrow_fields[0],
    coil_temp:      narrow_fields[1],
    voltage:        narrow_fields[2],
    power:          narrow_fields[3],
    op_mode:        narrow_fields[4],
    error_bits:     narrow_fields[5]
  };

endmodule

[hw/rtl/mrfc_out_stage.sv]
// Result register that presents one finished frame result to the sink.
module mrfc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_load,
  input  mrfc_pkg::result_t res,
  output logic              out_free,
  mrfc_out_if.source        out_ch
);
  import mrfc_pkg::*;

  logic    out_valid;
  result_t out_word;

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_word.status;
  assign out_ch.shaft_force    = out_word.shaft_force;
  assign out_ch.shaft_position = out_word.shaft_position;
  assign out_ch.speed          = out_word.speed;
  assign out_ch.acceleration   = out_word.acceleration;
  assign out_ch.board_temp     = out_word.board_temp;
  assign out_ch.coil_temp      = out_word.coil_temp;
  assign out_ch.voltage        = out_word.voltage;
  assign out_ch.power          = out_word.power;
  assign out_ch.op_mode        = out_word.op_mode;
  assign out_ch.error_bits     = out_word.error_bits;

endmodule

[hw/rtl/motor_response_frame_checker.sv]
// Top level of the motor response frame checker.
// Path: the last byte of a frame waits in the input register, is checked as the frame
// logic takes it, which loads the result register, and is then offered to the sink.
// Throughput: one byte per cycle; only the last byte of a frame waits, and only while
// the previous result is still held and not being taken in that cycle.
// Reset (sync, active high) empties both registers, restarts at byte 0, CRC 0xFFFF.
module motor_response_frame_checker (
  input logic         clk,
  input logic         rst,
  mrfc_in_if.sink     in_ch,
  mrfc_out_if.source  out_ch,
  mrfc_cfg_if.sink    cfg_ch
);
  import mrfc_pkg::*;

  // Word held in the input register and its valid flag.
  in_word_t word;
  logic     word_valid;

  // The frame logic takes the held word when it makes no result, or when the
  // result register is free (empty, or being drained in this cycle).
  logic    take;
  logic    res_load;
  logic    out_free;
  result_t res;

  // The input register accepts a new word when it is empty or its current word moves on,
  // so bytes stream in back to back while a finished result waits, up to the next last byte.
  mrfc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .take       (take),
    .word       (word),
    .word_valid (word_valid)
  );

  // Frame position, header checks, gathered telemetry words and the running CRC.
  // The configuration channel is always ready; writes land in this unit, and the
  // address and function code registers come out of reset as 1 and 0.
  mrfc_frame_proc u_frame_proc (
    .clk        (clk),
    .rst        (rst),
    .cfg_ch     (cfg_ch),
    .word       (word),
    .word_valid (word_valid),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  // One result per complete frame, held until the sink takes it.
  mrfc_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

[hw/rtl/mrfc_checker.sv]
// Port-level assertions for the frame checker and the bind that attaches them.
`include "motor_response_frame_checker_defines.svh"

module mrfc_checker (
  input logic        clk,
  input logic        rst,
  mrfc_in_if.sink    in_ch,
  mrfc_out_if.source out_ch,
  mrfc_cfg_if.sink   cfg_ch
);

  `MRFC_ASSERT_IMP(a_cfg_ready, cfg_ch.valid, cfg_ch.ready, "configuration write stalled")
  `MRFC_ASSERT_IMP(a_in_ready_out_empty, !out_ch.valid, in_ch.ready,
                   "input stalled with empty output")
  `MRFC_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
                    out_ch.valid && $stable(out_ch.status) && $stable(out_ch.error_bits),
                    "stalled result changed")
  `MRFC_ASSERT_ALWAYS(a_reset_empty, rst, !out_ch.valid, "result valid right after reset")

endmodule

bind motor_response_frame_checker mrfc_checker u_mrfc_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch),
  .cfg_ch (cfg_ch)
);

[tb/motor_response_frame_checker_tb.sv]
// Self-checking testbench for the motor response frame checker.
`timescale 1ns / 1ps

module motor_response_frame_checker_tb;
  import mrfc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  // Wait for the last accepted word to pass the input and result registers, plus margin.
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_WORDS = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;

  // Byte patterns for the telemetry part of a frame (bytes 2 to 35).
  typedef enum int {FILL_ZERO, FILL_ONES, FILL_ALT, FILL_MIN, FILL_MAX, FILL_RAND} fill_e;
  // Which trailing CRC byte, if any, is corrupted before the frame is sent.
  typedef enum int {CRC_GOOD, CRC_LO_BAD, CRC_HI_BAD} crc_fault_e;

  typedef struct packed {
    logic [7:0] cfg_addr;
    logic [7:0] cfg_func;
    logic [7:0] addr;
    logic [7:0] func;
    fill_e      fill;
    crc_fault_e fault;
    int         cut;
    logic       first_restart;
    logic       has_exp;
    logic [1:0] exp_status;
  } directed_row_t;

  // Directed frames. A nonzero cut sends that many leading bytes of the frame
  // first and then restarts, so the partial frame must vanish without a report.
  // The expected status is typed in only where it is obvious from the frame.
  localparam directed_row_t DIRECTED_ROWS [15] = '{
    '{8'd1,   8'd0,   8'd1,   8'd0,   FILL_ZERO, CRC_GOOD,   0,  1'b1, 1'b1, ST_OK},
    '{8'd1,   8'd0,   8'd1,   8'd0,   FILL_ONES, CRC_GOOD,   0,  1'b1, 1'b1, ST_OK},
    '{8'd1,   8'd0,   8'd2,   8'd0,   FILL_ALT,  CRC_GOOD,   0,  1'b1, 1'b1, ST_BAD_ADDR},
    '{8'd1,   8'd0,   8'd1,   8'd3,   FILL_RAND, CRC_GOOD,   0,  1'b1, 1'b1, ST_BAD_FUNC},
    '{8'd1,   8'd0,   8'd0,   8'd7,   FILL_RAND, CRC_GOOD,   0,  1'b1, 1'b1, ST_BAD_ADDR},
    '{8'd1,   8'd0,   8'd1,   8'd0,   FILL_RAND, CRC_LO_BAD, 0,  1'b1, 1'b1, ST_BAD_CRC},
    '{8'd1,   8'd0,   8'd1,   8'd9,   FILL_RAND, CRC_HI_BAD, 0,  1'b1, 1'b1, ST_BAD_FUNC},
    '{8'd1,   8'd0,   8'd1,   8'd0,   FILL_RAND, CRC_GOOD,   20, 1'b1, 1'b0, ST_OK},
    '{8'd1,   8'd0,   8'd1,   8'd0,   FILL_RAND, CRC_GOOD,   0,  1'b0, 1'b0, ST_OK},
    '{8'd247, 8'd255, 8'd247, 8'd255, FILL_MIN,  CRC_GOOD,   0,  1'b1, 1'b1, ST_OK},
    '{8'd247, 8'd255, 8'd255, 8'd255, FILL_MAX,  CRC_GOOD,   0,  1'b1, 1'b1, ST_BAD_ADDR},
    '{8'd247, 8'd255, 8'd247, 8'd254, FILL_ZERO, CRC_LO_BAD, 0,  1'b1, 1'b1, ST_BAD_FUNC},
    '{8'd0,   8'd0,   8'd0,   8'd0,   FILL_MAX,  CRC_GOOD,   0,  1'b1, 1'b1, ST_OK},
    '{8'd0,   8'd0,   8'd0,   8'd0,   FILL_MIN,  CRC_HI_BAD, 0,  1'b1, 1'b1, ST_BAD_CRC},
    '{8'd0,   8'd0,   8'd0,   8'd0,   FILL_ONES, CRC_GOOD,   37, 1'b1, 1'b0, ST_OK}
  };

  logic clk = 1'b0;
  logic rst;

  mrfc_in_if  rx_if ();
  mrfc_out_if rep_if ();
  mrfc_cfg_if reg_if ();

  motor_response_frame_checker dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (rx_if),
    .out_ch (rep_if),
    .cfg_ch (reg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Frame decoder state as the block should hold it, plus its two registers.
  logic [7:0]  want_address  = SLAVE_ADDRESS_RESET;
  logic [7:0]  want_function = FUNCTION_CODE_RESET;
  logic [5:0]  frame_pos     = '0;
  logic [15:0] frame_crc     = 16'hFFFF;
  logic [1:0]  header_code   = ST_OK;
  logic [31:0] wide_words [4]   = '{default: '0};
  logic [15:0] narrow_words [6] = '{default: '0};
  logic [7:0]  crc_lo_seen   = '0;

  // Frame reports that the block still owes, oldest first.
  result_t frame_reports_q [$];

  logic [7:0] frame_bytes [FRAME_LENGTH];

  int unsigned cycle_count      = 0;
  int unsigned words_sent       = 0;
  int unsigned frames_predicted = 0;
  int unsigned reports_checked  = 0;
  int unsigned failures         = 0;
  int unsigned config_loads     = 0;
  int unsigned holds_done       = 0;
  int unsigned status_seen [4]  = '{default: 0};

  // Idle odds in percent per word, stall odds per report-side burst; changed per phase.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  bit          long_hold_req = 1'b0;

  // Reflected CRC-16 with polynomial 0xA001, fed one data bit at a time.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] acc;
    logic        fb;
    acc = c;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ d[k];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ 16'hA001;
      end
    end
    return acc;
  endfunction

  // Advances the frame decoder by one accepted word and queues the report
  // that the last byte of a frame produces.
  task automatic track_frame_byte(input logic [7:0] b, input logic rs);
    result_t report;
    int      p;
    if (rs) begin
      frame_pos = '0;
    end
    p = frame_pos;

    // The first header error of a frame sticks, so a bad address hides a bad
    // function code, and either hides a bad CRC below.
    if (p == 0) begin
      frame_crc   = 16'hFFFF;
      header_code = (b != want_address) ? ST_BAD_ADDR : ST_OK;
    end else if (p == 1 && header_code == ST_OK && b != want_function) begin
      header_code = ST_BAD_FUNC;
    end

    // Telemetry words arrive big-endian and are shifted in byte by byte.
    if (p >= 2 && p <= 17) begin
      wide_words[(p - 2) / 4] = {wide_words[(p - 2) / 4][23:0], b};
    end else if (p >= 18 && p <= 27) begin
      narrow_words[(p - 18) / 2] = {narrow_words[(p - 18) / 2][7:0], b};
    end else if (p == 32 || p == 33) begin
      narrow_words[5] = {narrow_words[5][7:0], b};
    end

    if (p < FRAME_LENGTH - 2) begin
      frame_crc = crc_step(frame_crc, b);
      frame_pos = 6'(p + 1);
    end else if (p == FRAME_LENGTH - 2) begin
      crc_lo_seen = b;
      frame_pos   = 6'(p + 1);
    end else begin
      report.status = header_code;
      if (header_code == ST_OK && (crc_lo_seen != frame_crc[7:0] || b != frame_crc[15:8])) begin
        report.status = ST_BAD_CRC;
      end
      // The fields carry whatever this frame delivered, even on an error.
      report.shaft_force    = wide_words[0];
      report.shaft_position = wide_words[1];
      report.speed          = wide_words[2];
      report.acceleration   = wide_words[3];
      report.board_temp     = narrow_words[0];
      report.coil_temp      = narrow_words[1];
      report.voltage        = narrow_words[2];
      report.power          = narrow_words[3];
      report.op_mode        = narrow_words[4];
      report.error_bits     = narrow_words[5];
      frame_reports_q.push_back(report);
      frames_predicted++;
      // With no restart the next word is byte 0 of the next frame.
      frame_pos = '0;
    end
  endtask

  // Offers one word, with a random idle burst in front of it, and waits for
  // the block to take it. Valid is only dropped when a burst is due.
  task automatic send_byte(input logic [7:0] b, input logic rs);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.restart <= rs;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    words_sent++;
    track_frame_byte(b, rs);
  endtask

  // Builds a frame with the given header and fill, and a trailing CRC that is
  // correct unless a fault is asked for.
  task automatic fill_frame(input logic [7:0] a, input logic [7:0] f, input fill_e fill,
                            input crc_fault_e fault);
    logic [15:0] c;
    logic        head;
    frame_bytes[0] = a;
    frame_bytes[1] = f;
    for (int i = 2; i < FRAME_LENGTH - 2; i++) begin
      // The most significant byte of each reported field gets the sign pattern.
      head = (i >= 2 && i <= 17) ? ((i - 2) % 4 == 0) :
             (i >= 18 && i <= 27) ? ((i - 18) % 2 == 0) : (i == 32);
      case (fill)
        FILL_ZERO: frame_bytes[i] = 8'h00;
        FILL_ONES: frame_bytes[i] = 8'hFF;
        FILL_ALT:  frame_bytes[i] = (i % 2 != 0) ? 8'hAA : 8'h55;
        FILL_MIN:  frame_bytes[i] = head ? 8'h80 : 8'h00;
        FILL_MAX:  frame_bytes[i] = head ? 8'h7F : 8'hFF;
        default:   frame_bytes[i] = 8'($urandom_range(0, 255));
      endcase
    end
    c = 16'hFFFF;
    for (int i = 0; i < FRAME_LENGTH - 2; i++) begin
      c = crc_step(c, frame_bytes[i]);
    end
    frame_bytes[FRAME_LENGTH - 2] = c[7:0];
    frame_bytes[FRAME_LENGTH - 1] = c[15:8];
    if (fault == CRC_LO_BAD) begin
      frame_bytes[FRAME_LENGTH - 2] ^= 8'($urandom_range(1, 255));
    end else if (fault == CRC_HI_BAD) begin
      frame_bytes[FRAME_LENGTH - 1] ^= 8'($urandom_range(1, 255));
    end
  endtask

  // Sends the first count bytes of the built frame. Restart is forced on the
  // first byte whenever the decoder is not already at byte 0.
  task automatic send_frame(input logic first_restart, input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(frame_bytes[i], (i == 0) ? (first_restart || frame_pos != 0) : 1'b0);
    end
  endtask

  // One random piece of traffic: mostly well-formed frames with random
  // content, some cut short, and some plain noise with random restarts.
  task automatic send_random_frame();
    int          kind;
    int          pick;
    logic [7:0]  a;
    logic [7:0]  f;
    fill_e       fill;
    crc_fault_e  fault;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 60)) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end else begin
      a = ($urandom_range(0, 99) < 88) ? want_address
                                         : 8'(want_address + $urandom_range(1, 255));
      f = ($urandom_range(0, 99) < 88) ? want_function
                                         : 8'(want_function + $urandom_range(1, 255));
      fill = ($urandom_range(0, 9) == 0) ? fill_e'($urandom_range(0, 4)) : FILL_RAND;
      pick = $urandom_range(0, 99);
      fault = (pick < 6) ? CRC_LO_BAD : (pick < 12) ? CRC_HI_BAD : CRC_GOOD;
      fill_frame(a, f, fill, fault);
      send_frame($urandom_range(0, 1), (kind < 16) ? $urandom_range(1, FRAME_LENGTH - 1)
                                                     : FRAME_LENGTH);
    end
  endtask

  // Registers change only while the block is idle: input stopped, every owed
  // report collected, and a DRAIN_CYCLES wait for any word still inside the pipeline.
  task automatic load_registers(input logic [7:0] addr, input logic [7:0] func);
    rx_if.valid <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_if.valid <= 1'b1;
    reg_if.index <= CFG_SLAVE_ADDRESS;
    reg_if.data  <= addr;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
    want_address = addr;
    reg_if.index <= CFG_FUNCTION_CODE;
    reg_if.data  <= func;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
    want_function = func;
    reg_if.valid <= 1'b0;
    config_loads++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  // Report side: random stall bursts, plus one long hold-off on request that
  // lets the sender fill the block until it refuses input.
  initial begin
    forever begin
      if (long_hold_req) begin
        rep_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        holds_done++;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        rep_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        rep_if.ready <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // Every accepted report is compared field by field with the oldest one owed.
  always @(posedge clk) begin
    result_t want;
    if (!rst && rep_if.valid && rep_if.ready) begin
      if (frame_reports_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("[%0t] report with none owed: status %0d", $realtime, rep_if.status);
        end
      end else begin
        want = frame_reports_q.pop_front();
        check_field("status",         32'(want.status),     32'(rep_if.status));
        check_field("shaft_force",    want.shaft_force,     rep_if.shaft_force);
        check_field("shaft_position", want.shaft_position,  rep_if.shaft_position);
        check_field("speed",          want.speed,           rep_if.speed);
        check_field("acceleration",   want.acceleration,    rep_if.acceleration);
        check_field("board_temp",     32'(want.board_temp), 32'(rep_if.board_temp));
        check_field("coil_temp",      32'(want.coil_temp),  32'(rep_if.coil_temp));
        check_field("voltage",        32'(want.voltage),    32'(rep_if.voltage));
        check_field("power",          32'(want.power),      32'(rep_if.power));
        check_field("op_mode",        32'(want.op_mode),    32'(rep_if.op_mode));
        check_field("error_bits",     32'(want.error_bits), 32'(rep_if.error_bits));
        reports_checked++;
        status_seen[rep_if.status]++;
      end
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d reports owed", cycle_count,
               frame_reports_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    int unsigned   owed_before;
    int unsigned   random_start;
    int unsigned   phase;
    logic [7:0]    next_addr;
    logic [7:0]    next_func;

    rst            <= 1'b1;
    rx_if.valid    <= 1'b0;
    rx_if.rx_byte  <= '0;
    rx_if.restart  <= 1'b0;
    reg_if.valid   <= 1'b0;
    reg_if.index   <= CFG_SLAVE_ADDRESS;
    reg_if.data    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed frames: header errors and their precedence, CRC faults in
    // either byte, field extremes, frames cut short by a restart, a frame
    // that starts without restart, and register settings at their extremes.
    idle_pct  = 30;
    stall_pct = 30;
    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      row = DIRECTED_ROWS[r];
      if (row.cfg_addr != want_address || row.cfg_func != want_function) begin
        load_registers(row.cfg_addr, row.cfg_func);
      end
      fill_frame(row.addr, row.func, row.fill, row.fault);
      if (row.cut != 0) begin
        send_frame(1'b1, row.cut);
      end
      owed_before = frames_predicted;
      send_frame(row.first_restart, FRAME_LENGTH);
      // The report has not yet reached the sink, so the typed status can
      // replace the predicted one in the queue.
      if (row.has_exp && frames_predicted != owed_before) begin
        frame_reports_q[$].status = row.exp_status;
      end
    end

    // Random phases, each under fresh register values and idle odds. The
    // third phase also asks the report side for its long hold-off.
    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0:       next_addr = 8'd0;
        1:       next_addr = 8'd247;
        default: next_addr = 8'($urandom_range(0, 247));
      endcase
      case ($urandom_range(0, 3))
        0:       next_func = 8'd0;
        1:       next_func = 8'd255;
        default: next_func = 8'($urandom_range(0, 255));
      endcase
      load_registers(next_addr, next_func);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        default: stall_pct = 50;
      endcase
      if (phase == 2) begin
        idle_pct      = 0;
        long_hold_req = 1'b1;
      end
      repeat (6) send_random_frame();
      phase++;
    end

    // Closing stretch at full rate on both sides.
    idle_pct  = 0;
    stall_pct = 0;
    repeat (5) send_random_frame();

    rx_if.valid <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);

    $display("Sent %0d words in %0d register settings with %0d long hold-off(s).",
             words_sent, config_loads + 1, holds_done);
    $display("Checked %0d reports: %0d ok, %0d bad address, %0d bad function, %0d bad CRC.",
             reports_checked, status_seen[ST_OK], status_seen[ST_BAD_ADDR],
             status_seen[ST_BAD_FUNC], status_seen[ST_BAD_CRC]);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mrfc_pkg.sv
hw/rtl/mrfc_ifs.sv
hw/rtl/mrfc_in_stage.sv
hw/rtl/mrfc_frame_proc.sv
hw/rtl/mrfc_out_stage.sv
hw/rtl/motor_response_frame_checker.sv
hw/rtl/mrfc_checker.sv
tb/motor_response_frame_checker_tb.sv
